// File: hdl/men_pkg.sv
// Shared constants and types of the mesh edge numbering block.
package men_pkg;

  localparam int VERTEX_BITS_DEF = 24;
  localparam int MAX_EDGES_DEF   = 4096;
  localparam int TABLE_SLOTS_DEF = 8192;

  localparam int EDGE_W   = 12;
  localparam int DIM_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [DIM_W-1:0] DIM_TRI   = 2'd2;
  localparam logic [DIM_W-1:0] DIM_RESET = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  localparam int EDGES_TRI = 3;
  localparam int EDGES_TET = 6;
  localparam int EDGE_IDX_W = 3;

  // local edge table: start corner and end corner of each local edge
  localparam logic [1:0] EDGE_END_A [EDGES_TET] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
  localparam logic [1:0] EDGE_END_B [EDGES_TET] = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd3, 2'd3};

  localparam logic [63:0] HASH_LO_MULT = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] HASH_HI_MULT = 64'hC2B2_AE3D_27D4_EB4F;
  localparam int          HASH_SHIFT   = 29;

  typedef struct packed {
    logic                done;
    logic                fresh;
    logic [STATUS_W-1:0] status;
    logic [EDGE_W-1:0]   edge_number;
  } probe_rsp_t;

endpackage

// File: hdl/men_if.sv
// Request channels of the mesh edge numbering block: cells in, edge results out.
interface men_cell_if #(
  parameter int VERTEX_BITS = men_pkg::VERTEX_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VERTEX_BITS-1:0] corner_first;
  logic [VERTEX_BITS-1:0] corner_second;
  logic [VERTEX_BITS-1:0] corner_third;
  logic [VERTEX_BITS-1:0] corner_fourth;

  modport source (output valid, corner_first, corner_second, corner_third, corner_fourth,
                  input ready);
  modport sink (input valid, corner_first, corner_second, corner_third, corner_fourth,
                output ready);
endinterface

interface men_edge_if #(
  parameter int VERTEX_BITS = men_pkg::VERTEX_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [men_pkg::EDGE_W-1:0]    edge_number;
  logic                          orientation_negative;
  logic                          first_seen;
  logic [VERTEX_BITS-1:0]        low_vertex;
  logic [VERTEX_BITS-1:0]        high_vertex;
  logic [men_pkg::STATUS_W-1:0]  status;
  logic                          last_of_cell;

  modport source (output valid, edge_number, orientation_negative, first_seen, low_vertex,
                  high_vertex, status, last_of_cell, input ready);
  modport sink (input valid, edge_number, orientation_negative, first_seen, low_vertex,
                high_vertex, status, last_of_cell, output ready);
endinterface

// File: hdl/mesh_edge_numbering.sv
// Mesh edge numbering: per-cell edge sequencer, corner check and result register.
//
// A cell enters on cell_i (valid/ready); each of its local edges leaves as one
// request on edge_o, three for triangles (dimension 2) and six otherwise, the
// final one flagged last_of_cell. A cell that repeats a corner gives a single
// result with status 1. Edge ids follow first appearance; status 2 marks an
// edge that found no room in the table.
// Cells are handled one at a time. Each edge passes through corner selection,
// the registered hash stages, one memory read per probe of the edge table plus
// its response, and the result register; each extra linear probe adds one more
// table read. The table memory read port sets the probe rate.
// After reset the used-bit memory is swept, one slot a cycle, over all
// TABLE_SLOTS slots (8192 by default) before the first cell is taken; dimension
// resets to 3 and may be written at any time on cfg_we_i. TABLE_SLOTS must be
// a power of two; the block itself does not enforce it. A stalled receiver
// holds the result register and the sequencer waits; the next cell is taken
// while the last result of a cell is still waiting.
module mesh_edge_numbering #(
  parameter int VERTEX_BITS = men_pkg::VERTEX_BITS_DEF,
  parameter int MAX_EDGES   = men_pkg::MAX_EDGES_DEF,
  parameter int TABLE_SLOTS = men_pkg::TABLE_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [men_pkg::DIM_W-1:0]   cfg_wdata_i,
  men_cell_if.sink                    cell_i,
  men_edge_if.source                  edge_o
);
  localparam int ADDR_W = $clog2(TABLE_SLOTS);
  localparam int KW     = men_pkg::EDGE_IDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DUP   = 3'd1;
  localparam logic [2:0] S_EDGE  = 3'd2;
  localparam logic [2:0] S_HASH  = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [men_pkg::DIM_W-1:0] dim_q;
  logic                      tri_q;
  logic [KW-1:0]             k_q, k_d;
  logic [VERTEX_BITS-1:0]    c0_q, c1_q, c2_q, c3_q;
  logic [VERTEX_BITS-1:0]    p, q, lo, hi;
  logic [VERTEX_BITS-1:0]    lo_q, hi_q;
  logic                      neg_q;
  men_pkg::probe_rsp_t       rsp, rsp_q;

  logic                      hash_start, hash_done;
  logic [ADDR_W-1:0]         hash_slot;
  logic                      probe_start, probe_ready;

  logic                      dup, last_edge, out_free, take_cell;
  logic                      load_dup, load_edge;

  logic                          out_valid_q;
  logic [men_pkg::EDGE_W-1:0]    out_edge_q;
  logic                          out_neg_q, out_fresh_q, out_last_q;
  logic [VERTEX_BITS-1:0]        out_lo_q, out_hi_q;
  logic [men_pkg::STATUS_W-1:0]  out_status_q;

  function automatic logic [VERTEX_BITS-1:0] pick(
    input logic [1:0]             idx,
    input logic [VERTEX_BITS-1:0] a0,
    input logic [VERTEX_BITS-1:0] a1,
    input logic [VERTEX_BITS-1:0] a2,
    input logic [VERTEX_BITS-1:0] a3
  );
    logic [VERTEX_BITS-1:0] r;
    case (idx)
      2'd0:    r = a0;
      2'd1:    r = a1;
      2'd2:    r = a2;
      default: r = a3;
    endcase
    return r;
  endfunction

  assign p  = pick(men_pkg::EDGE_END_A[k_q], c0_q, c1_q, c2_q, c3_q);
  assign q  = pick(men_pkg::EDGE_END_B[k_q], c0_q, c1_q, c2_q, c3_q);
  assign lo = (p < q) ? p : q;
  assign hi = (p < q) ? q : p;

  assign dup = (c0_q == c1_q) || (c0_q == c2_q) || (c1_q == c2_q) ||
               (!tri_q && ((c0_q == c3_q) || (c1_q == c3_q) || (c2_q == c3_q)));
  assign last_edge = tri_q ? (k_q == KW'(men_pkg::EDGES_TRI - 1))
                           : (k_q == KW'(men_pkg::EDGES_TET - 1));

  assign out_free  = !out_valid_q || edge_o.ready;
  assign take_cell = cell_i.valid && cell_i.ready;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    hash_start  = 1'b0;
    probe_start = 1'b0;
    load_dup    = 1'b0;
    load_edge   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (take_cell) begin
          k_d     = '0;
          state_d = S_DUP;
        end
      end
      S_DUP: begin
        if (!dup) begin
          state_d = S_EDGE;
        end else if (out_free) begin
          load_dup = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_EDGE: begin
        hash_start = 1'b1;
        state_d    = S_HASH;
      end
      S_HASH: begin
        if (hash_done) begin
          probe_start = 1'b1;
          state_d     = S_PROBE;
        end
      end
      S_PROBE: begin
        if (rsp.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_edge = 1'b1;
          if (last_edge) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_EDGE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      dim_q       <= men_pkg::DIM_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        dim_q <= cfg_wdata_i;
      end
      if (load_dup || load_edge) begin
        out_valid_q <= 1'b1;
      end else if (edge_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_cell) begin
      c0_q  <= cell_i.corner_first;
      c1_q  <= cell_i.corner_second;
      c2_q  <= cell_i.corner_third;
      c3_q  <= cell_i.corner_fourth;
      tri_q <= (dim_q == men_pkg::DIM_TRI);
    end
    if (hash_start) begin
      lo_q  <= lo;
      hi_q  <= hi;
      neg_q <= (p > q);
    end
    if (rsp.done) begin
      rsp_q <= rsp;
    end
    if (load_dup) begin
      out_edge_q   <= '0;
      out_neg_q    <= 1'b0;
      out_fresh_q  <= 1'b0;
      out_lo_q     <= '0;
      out_hi_q     <= '0;
      out_status_q <= men_pkg::ST_DUP;
      out_last_q   <= 1'b1;
    end else if (load_edge) begin
      out_edge_q   <= rsp_q.edge_number;
      out_neg_q    <= neg_q;
      out_fresh_q  <= rsp_q.fresh;
      out_lo_q     <= lo_q;
      out_hi_q     <= hi_q;
      out_status_q <= rsp_q.status;
      out_last_q   <= last_edge;
    end
  end

  men_hash #(
    .VERTEX_BITS (VERTEX_BITS),
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .lo_i    (lo),
    .hi_i    (hi),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  men_probe #(
    .VERTEX_BITS (VERTEX_BITS),
    .MAX_EDGES   (MAX_EDGES),
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_probe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (probe_start),
    .slot_i  (hash_slot),
    .lo_i    (lo_q),
    .hi_i    (hi_q),
    .ready_o (probe_ready),
    .rsp_o   (rsp)
  );

  assign cell_i.ready              = (state_q == S_IDLE) && probe_ready;
  assign edge_o.valid              = out_valid_q;
  assign edge_o.edge_number        = out_edge_q;
  assign edge_o.orientation_negative = out_neg_q;
  assign edge_o.first_seen         = out_fresh_q;
  assign edge_o.low_vertex         = out_lo_q;
  assign edge_o.high_vertex        = out_hi_q;
  assign edge_o.status             = out_status_q;
  assign edge_o.last_of_cell       = out_last_q;
endmodule

// File: hdl/men_hash.sv
// Two-stage hash of an edge key (low, high vertex) to its home slot.
module men_hash #(
  parameter int VERTEX_BITS = men_pkg::VERTEX_BITS_DEF,
  parameter int TABLE_SLOTS = men_pkg::TABLE_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [VERTEX_BITS-1:0]         lo_i,
  input  logic [VERTEX_BITS-1:0]         hi_i,
  output logic                           done_o,
  output logic [$clog2(TABLE_SLOTS)-1:0] slot_o
);
  localparam int ADDR_W = $clog2(TABLE_SLOTS);

  logic [31:0] lo32, hi32;
  logic [63:0] p0_d, p2_d;
  logic [31:0] p1_d, p3_d;
  logic [63:0] p0_q, p2_q;
  logic [31:0] p1_q, p3_q;
  logic        s1_q, done_q;
  logic [63:0] m1, m2, h, g;
  logic [ADDR_W-1:0] slot_d, slot_q;

  assign lo32 = 32'(lo_i);
  assign hi32 = 32'(hi_i);
  assign p0_d = lo32 * men_pkg::HASH_LO_MULT[31:0];
  assign p1_d = lo32 * men_pkg::HASH_LO_MULT[63:32];
  assign p2_d = hi32 * men_pkg::HASH_HI_MULT[31:0];
  assign p3_d = hi32 * men_pkg::HASH_HI_MULT[63:32];

  // products mod 2^64, then fold high bits down
  assign m1     = p0_q + {p1_q, 32'h0};
  assign m2     = p2_q + {p3_q, 32'h0};
  assign h      = m1 ^ m2;
  assign g      = h ^ (h >> men_pkg::HASH_SHIFT);
  assign slot_d = g[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      done_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
    end
    if (s1_q) begin
      slot_q <= slot_d;
    end
  end

  assign done_o = done_q;
  assign slot_o = slot_q;
endmodule

// File: hdl/men_probe.sv
// Edge table: used-bit and entry memories, linear probe, insert and clearing pass.
module men_probe #(
  parameter int VERTEX_BITS = men_pkg::VERTEX_BITS_DEF,
  parameter int MAX_EDGES   = men_pkg::MAX_EDGES_DEF,
  parameter int TABLE_SLOTS = men_pkg::TABLE_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [$clog2(TABLE_SLOTS)-1:0] slot_i,
  input  logic [VERTEX_BITS-1:0]         lo_i,
  input  logic [VERTEX_BITS-1:0]         hi_i,
  output logic                           ready_o,
  output men_pkg::probe_rsp_t            rsp_o
);
  localparam int ADDR_W  = $clog2(TABLE_SLOTS);
  localparam int LIMIT   = (MAX_EDGES < TABLE_SLOTS) ? MAX_EDGES : TABLE_SLOTS;
  localparam int CNT_W   = $clog2(LIMIT + 1);
  localparam int ID_W    = $clog2(LIMIT);
  localparam int ENTRY_W = 2 * VERTEX_BITS + ID_W;

  localparam logic [1:0] P_CLEAR = 2'd0;
  localparam logic [1:0] P_IDLE  = 2'd1;
  localparam logic [1:0] P_CHECK = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [ADDR_W-1:0]      addr_q, addr_d, next_addr, clr_q, clr_d;
  logic [ADDR_W:0]        probes_q, probes_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [VERTEX_BITS-1:0] key_lo_q, key_hi_q;
  men_pkg::probe_rsp_t    rsp_q, rsp_d;

  logic                   used_mem [TABLE_SLOTS];
  logic [ENTRY_W-1:0]     entry_mem [TABLE_SLOTS];
  logic                   used_rd_q;
  logic [ENTRY_W-1:0]     entry_rd_q;

  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   used_we, used_wd, ent_we;
  logic [ADDR_W-1:0]      used_wa;
  logic [VERTEX_BITS-1:0] stored_lo, stored_hi;
  logic [ID_W-1:0]        stored_id;
  logic                   match;

  assign stored_lo = entry_rd_q[ENTRY_W-1 -: VERTEX_BITS];
  assign stored_hi = entry_rd_q[ID_W +: VERTEX_BITS];
  assign stored_id = entry_rd_q[ID_W-1:0];
  assign match     = (stored_lo == key_lo_q) && (stored_hi == key_hi_q);
  assign next_addr = (addr_q == ADDR_W'(TABLE_SLOTS - 1)) ? '0 : addr_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    addr_d   = addr_q;
    clr_d    = clr_q;
    probes_d = probes_q;
    count_d  = count_q;
    rsp_d    = '0;
    rd_en    = 1'b0;
    rd_addr  = slot_i;
    used_we  = 1'b0;
    used_wa  = addr_q;
    used_wd  = 1'b0;
    ent_we   = 1'b0;
    case (state_q)
      P_CLEAR: begin
        used_we = 1'b1;
        used_wa = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == ADDR_W'(TABLE_SLOTS - 1)) begin
          state_d = P_IDLE;
        end
      end
      P_IDLE: begin
        if (start_i) begin
          rd_en    = 1'b1;
          rd_addr  = slot_i;
          addr_d   = slot_i;
          probes_d = '0;
          state_d  = P_CHECK;
        end
      end
      P_CHECK: begin
        if (!used_rd_q) begin
          rsp_d.done = 1'b1;
          state_d    = P_IDLE;
          if (count_q == CNT_W'(LIMIT)) begin
            rsp_d.status = men_pkg::ST_FULL;
          end else begin
            used_we           = 1'b1;
            used_wa           = addr_q;
            used_wd           = 1'b1;
            ent_we            = 1'b1;
            count_d           = count_q + 1'b1;
            rsp_d.status      = men_pkg::ST_OK;
            rsp_d.fresh       = 1'b1;
            rsp_d.edge_number = men_pkg::EDGE_W'(count_q);
          end
        end else if (match) begin
          rsp_d.done        = 1'b1;
          rsp_d.status      = men_pkg::ST_OK;
          rsp_d.edge_number = men_pkg::EDGE_W'(stored_id);
          state_d           = P_IDLE;
        end else if (probes_q == (ADDR_W + 1)'(TABLE_SLOTS - 1)) begin
          // every slot holds some other edge
          rsp_d.done   = 1'b1;
          rsp_d.status = men_pkg::ST_FULL;
          state_d      = P_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = next_addr;
          addr_d   = next_addr;
          probes_d = probes_q + 1'b1;
        end
      end
      default: begin
        state_d = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= P_CLEAR;
      clr_q    <= '0;
      count_q  <= '0;
      rsp_q    <= '0;
      addr_q   <= '0;
      probes_q <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      count_q  <= count_d;
      rsp_q    <= rsp_d;
      addr_q   <= addr_d;
      probes_q <= probes_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == P_IDLE)) begin
      key_lo_q <= lo_i;
      key_hi_q <= hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    if (ent_we) begin
      entry_mem[addr_q] <= {key_lo_q, key_hi_q, ID_W'(count_q)};
    end
    if (rd_en) begin
      used_rd_q  <= used_mem[rd_addr];
      entry_rd_q <= entry_mem[rd_addr];
    end
  end

  assign ready_o = (state_q == P_IDLE);
  assign rsp_o   = rsp_q;
endmodule
